FILE: sv/rda_pkg.sv
// package: shared constants, types and root table for the rda l1 weight update unit
`timescale 1ns / 1ps

package rda_pkg;

  localparam int FEATURE_COUNT_DEF = 1024;

  localparam int IDX_W   = 10;
  localparam int GRAD_W  = 32;
  localparam int WGT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int SCALE_W = 48;
  localparam int DECAY_W = 18;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE   = 2'd2;

  localparam logic [31:0]        STEP_RESET  = 32'd65536;
  localparam logic [31:0]        THR_RESET   = 32'd0;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 18'd32768;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 48'd65536;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = {SCALE_W{1'b1}};

  localparam int FRAC_STEPS = 16;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef logic [30:0] root_tab_t [FRAC_STEPS];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // roots 2^(2^-k) in q1.30, k = 1 .. 16
  function automatic root_tab_t root_table();
    root_tab_t tab;
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int k = 0; k < FRAC_STEPS; k++) begin
      root = isqrt64(root << 30);
      tab[k] = root[30:0];
    end
    return tab;
  endfunction

endpackage

FILE: sv/rda_l1_weight_update_unit.sv
// top level: l1 dual averaging weight update with per-feature gradient sum memory
`timescale 1ns / 1ps

// Each accepted word adds grad_value to the 48-bit running sum of its feature
// (read-modify-write of one synchronous memory) and returns one word with the
// feature's new weight. The 48-step restoring divider forms sum / t and, only
// when the average exceeds the threshold, three 48x16 multiply steps apply the
// batch scale; a feature outside FEATURE_COUNT skips both. One item is in
// flight at a time, and the next word is taken only once the result has been
// issued, which a stalled output delays. After an end_of_batch word (unless the
// batch count is at its maximum), and after writes of step_size or decay_rate,
// the batch scale unit (log2 by 16 squarings, then 2^frac by 16 root products)
// runs before the next word or write is taken. After reset the sum memory is
// cleared, one entry per cycle; configuration is taken once that ends.
module rda_l1_weight_update_unit #(
  parameter int FEATURE_COUNT = rda_pkg::FEATURE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rda_pkg::IDX_W-1:0]      feature_index,
  input  logic signed [rda_pkg::GRAD_W-1:0] grad_value,
  input  logic                           end_of_batch,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rda_pkg::IDX_W-1:0]      weight_index,
  output logic signed [rda_pkg::WGT_W-1:0] weight_value,
  output logic                           weight_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rda_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int SUM_W = rda_pkg::SUM_W;
  localparam int CNT_W = rda_pkg::CNT_W;
  localparam int DIV_STEPS = SUM_W;
  localparam int MUL_STEPS = SUM_W / 16;
  localparam rda_pkg::root_tab_t ROOT = rda_pkg::root_table();

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_LOG   = 4'd8;
  localparam logic [3:0] S_LOGSQ = 4'd9;
  localparam logic [3:0] S_QMUL  = 4'd10;
  localparam logic [3:0] S_EXP   = 4'd11;
  localparam logic [3:0] S_PROD  = 4'd12;
  localparam logic [3:0] S_SHIFT = 4'd13;

  logic [3:0] state;
  logic [AW-1:0] clear_addr;
  logic [5:0] iter;

  logic [31:0] step_size;
  logic [31:0] l1_threshold;
  logic signed [rda_pkg::DECAY_W-1:0] decay_rate;
  logic [CNT_W-1:0] batch_count;
  logic [SUM_W-1:0] batch_scale;

  logic [rda_pkg::IDX_W-1:0] item_index;
  logic signed [rda_pkg::GRAD_W-1:0] item_grad;
  logic item_eob;

  logic signed [SUM_W-1:0] sum_mem [FEATURE_COUNT];
  logic signed [SUM_W-1:0] rd_data;

  logic s_neg;
  logic res_zero;
  logic [SUM_W-1:0] div_q;
  logic [CNT_W-1:0] div_r;
  logic [SUM_W-1:0] diff;
  logic [2*SUM_W-1:0] acc;

  logic [4:0] log_e;
  logic [30:0] log_m;
  logic [15:0] log_frac;
  logic [7:0] exp_int;
  logic [15:0] exp_frac;
  logic [30:0] mant;
  logic [62:0] prod;

  // address and range
  logic [AW+rda_pkg::IDX_W-1:0] idx_wide;
  logic [AW-1:0] idx_addr;
  logic in_range;
  assign idx_wide = (AW+rda_pkg::IDX_W)'(item_index);
  assign idx_addr = idx_wide[AW-1:0];
  assign in_range = 32'(item_index) < 32'(FEATURE_COUNT);

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE) | cfg_valid;

  // sum update
  logic signed [SUM_W:0] sum_raw;
  logic signed [SUM_W-1:0] s_new;
  logic [SUM_W-1:0] mag_sum;
  always_comb begin
    sum_raw = (SUM_W+1)'(rd_data) + (SUM_W+1)'(item_grad);
    if (sum_raw > $signed((SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}}))) begin
      s_new = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (sum_raw < $signed({2'b11, {(SUM_W-1){1'b0}}})) begin
      s_new = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      s_new = sum_raw[SUM_W-1:0];
    end
    mag_sum = s_new[SUM_W-1] ? SUM_W'(-s_new) : SUM_W'(s_new);
  end

  // divider step
  logic [CNT_W:0] r_sh;
  logic [CNT_W:0] r_sub;
  always_comb begin
    r_sh  = {div_r, div_q[SUM_W-1]};
    r_sub = r_sh - {1'b0, batch_count};
  end

  // result from the full product
  logic [79:0] mag_full;
  logic [31:0] limit;
  logic over;
  logic [31:0] mag;
  logic [31:0] wout;
  always_comb begin
    mag_full = acc[2*SUM_W-1:16];
    limit = s_neg ? 32'h7fff_ffff : 32'h8000_0000;
    over = (|mag_full[79:32]) || (mag_full[31:0] > limit);
    mag = over ? limit : mag_full[31:0];
    wout = s_neg ? mag : (32'd0 - mag);
    if (res_zero) begin
      wout = 32'd0;
      over = 1'b0;
    end
  end

  // log2 setup
  logic [4:0] top_bit;
  logic [61:0] norm;
  always_comb begin
    top_bit = 5'd0;
    for (int i = 0; i < CNT_W; i++) begin
      if (batch_count[i]) top_bit = 5'(i);
    end
    norm = (62'(batch_count) << 30) >> top_bit;
  end

  logic [61:0] sq;
  logic [61:0] mprod;
  logic signed [39:0] q_prod;
  assign sq = 62'(log_m) * 62'(log_m);
  assign mprod = 62'(mant) * 62'(ROOT[iter[3:0]]);
  assign q_prod = 40'(decay_rate) * 40'($signed({1'b0, log_e, log_frac}));

  // final scale shift
  logic [SUM_W-1:0] scale_new;
  logic [5:0] rsh;
  logic [6:0] lsh;
  logic [62:0] pr;
  logic ovf;
  always_comb begin
    rsh = 6'(8'd158 - exp_int);
    lsh = 7'(exp_int - 8'd158);
    pr = prod >> rsh;
    ovf = 1'b0;
    scale_new = '0;
    if (exp_int <= 8'd94) begin
      scale_new = '0;
    end else if (exp_int <= 8'd158) begin
      scale_new = (pr > 63'(rda_pkg::SCALE_MAX)) ? rda_pkg::SCALE_MAX : pr[SUM_W-1:0];
    end else begin
      if (lsh >= 7'd48) ovf = (prod != 63'd0);
      else ovf = ((prod >> (7'd48 - lsh)) != 63'd0);
      scale_new = ovf ? rda_pkg::SCALE_MAX : SUM_W'(prod << lsh);
    end
  end

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic signed [SUM_W-1:0] mem_wdata;
  assign mem_we = (state == S_CLEAR) || (state == S_SUM && in_range);
  assign mem_waddr = (state == S_CLEAR) ? clear_addr : idx_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : s_new;

  always_ff @(posedge clk) begin
    if (mem_we) sum_mem[mem_waddr] <= mem_wdata;
    rd_data <= sum_mem[idx_addr];
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_addr <= '0;
      iter <= '0;
      out_valid <= 1'b0;
      step_size <= rda_pkg::STEP_RESET;
      l1_threshold <= rda_pkg::THR_RESET;
      decay_rate <= rda_pkg::DECAY_RESET;
      batch_count <= CNT_W'(1);
      batch_scale <= rda_pkg::SCALE_RESET;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(FEATURE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              rda_pkg::REG_STEP_SIZE: begin
                step_size <= cfg_data;
                state <= S_LOG;
              end
              rda_pkg::REG_L1_THRESHOLD: l1_threshold <= cfg_data;
              rda_pkg::REG_DECAY_RATE: begin
                decay_rate <= cfg_data[rda_pkg::DECAY_W-1:0];
                state <= S_LOG;
              end
              default: ;
            endcase
          end else if (in_valid) begin
            item_index <= feature_index;
            item_grad <= grad_value;
            item_eob <= end_of_batch;
            state <= S_READ;
          end
        end
        S_READ: state <= S_SUM;
        S_SUM: begin
          s_neg <= s_new[SUM_W-1];
          div_q <= mag_sum;
          div_r <= '0;
          iter <= '0;
          res_zero <= 1'b1;
          state <= in_range ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (!r_sub[CNT_W]) begin
            div_r <= r_sub[CNT_W-1:0];
            div_q <= {div_q[SUM_W-2:0], 1'b1};
          end else begin
            div_r <= r_sh[CNT_W-1:0];
            div_q <= {div_q[SUM_W-2:0], 1'b0};
          end
          iter <= iter + 6'd1;
          if (iter == 6'(DIV_STEPS - 1)) state <= S_DIFF;
        end
        S_DIFF: begin
          diff <= div_q - SUM_W'(l1_threshold);
          acc <= '0;
          iter <= '0;
          if (div_q > SUM_W'(l1_threshold)) begin
            res_zero <= 1'b0;
            state <= S_MUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_MUL: begin
          acc <= (acc << 16) + (2*SUM_W)'(64'(batch_scale) * 64'(diff[SUM_W-1 -: 16]));
          diff <= diff << 16;
          iter <= iter + 6'd1;
          if (iter == 6'(MUL_STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            weight_index <= item_index;
            weight_value <= wout;
            weight_saturated <= over;
            if (item_eob && batch_count != {CNT_W{1'b1}}) begin
              batch_count <= batch_count + CNT_W'(1);
              state <= S_LOG;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_LOG: begin
          log_e <= top_bit;
          log_m <= norm[30:0];
          iter <= '0;
          state <= S_LOGSQ;
        end
        S_LOGSQ: begin
          if (sq[61]) begin
            log_m <= sq[61:31];
            log_frac <= {log_frac[14:0], 1'b1};
          end else begin
            log_m <= sq[60:30];
            log_frac <= {log_frac[14:0], 1'b0};
          end
          iter <= iter + 6'd1;
          if (iter == 6'(rda_pkg::FRAC_STEPS - 1)) state <= S_QMUL;
        end
        S_QMUL: begin
          exp_int <= {~q_prod[39], q_prod[38:32]};
          exp_frac <= q_prod[31:16];
          mant <= rda_pkg::ONE_Q30;
          iter <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (exp_frac[15]) mant <= mprod[60:30];
          exp_frac <= exp_frac << 1;
          iter <= iter + 6'd1;
          if (iter == 6'(rda_pkg::FRAC_STEPS - 1)) state <= S_PROD;
        end
        S_PROD: begin
          prod <= 63'(step_size) * 63'(mant);
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          batch_scale <= scale_new;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    batch_count != '0) else $error("batch count reached zero");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_READ) else $error("accepted word not read");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && weight_saturated |->
      weight_value == 32'sh7fff_ffff || weight_value == $signed(32'h8000_0000))
    else $error("saturated weight not at a limit");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall && !cfg_ready) else $error("traffic during clear");

endmodule

FILE: sim/tb_rda_l1_weight_update_unit.sv
// testbench: randomized and directed check of the rda l1 weight update unit against a local predictor
`timescale 1ns / 1ps

module tb_rda_l1_weight_update_unit;

  typedef struct {
    logic [rda_pkg::IDX_W-1:0]         idx;
    logic signed [rda_pkg::GRAD_W-1:0] grad;
    logic                              eob;
  } grad_word_t;

  typedef struct {
    logic [rda_pkg::IDX_W-1:0]        idx;
    logic signed [rda_pkg::WGT_W-1:0] value;
    logic                             sat;
  } weight_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rda_pkg::IDX_W-1:0] feature_index = '0;
  logic signed [rda_pkg::GRAD_W-1:0] grad_value = '0;
  logic end_of_batch = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rda_pkg::IDX_W-1:0] weight_index;
  logic signed [rda_pkg::WGT_W-1:0] weight_value;
  logic weight_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rda_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rda_pkg::CFG_W-1:0] cfg_data = '0;

  rda_l1_weight_update_unit dut (.*);

  always #5 clk = ~clk;

  // predictor state
  longint sums [rda_pkg::FEATURE_COUNT_DEF];
  int unsigned t_count;
  longint unsigned scale;
  logic [31:0] alpha;
  logic [31:0] lambda;
  logic signed [rda_pkg::DECAY_W-1:0] decay;

  grad_word_t grad_words[$];
  weight_word_t expected_weights[$];
  grad_word_t nxt;
  int n_sent = 0, n_recv = 0, n_err = 0, n_sat = 0, n_batches = 0, n_cfg = 0;
  bit quiet;

  function automatic longint unsigned int_sqrt(longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_count(int unsigned t);
    int e;
    longint unsigned m, l;
    e = 0;
    while (e < 31 && (t >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (longint'(t) << (30 - e)) : (longint'(t) >> (e - 30));
    l = longint'(e) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        l = l | (64'd1 << i);
      end
    end
    return l;
  endfunction

  function automatic longint unsigned pow2_frac(logic [15:0] f);
    longint unsigned mant, root;
    mant = 64'd1 << 30;
    root = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      root = int_sqrt(root << 30);
      if (f[16-k]) mant = (mant * root) >> 30;
    end
    return mant;
  endfunction

  function automatic void refresh_scale();
    longint q;
    longint unsigned uq, prod, smax;
    int n, sh;
    smax = rda_pkg::SCALE_MAX;
    q = longint'(decay) * longint'(log2_count(t_count));
    uq = longint'(q) + (64'd1 << 39);
    n = int'(uq >> 32) - 128;
    prod = longint'(alpha) * pow2_frac(uq[31:16]);
    sh = 30 - n;
    if (sh >= 64) scale = 0;
    else if (sh >= 0) begin
      prod = prod >> sh;
      scale = prod > smax ? smax : prod;
    end else begin
      if (prod > (smax >> (-sh))) scale = smax;
      else scale = prod << (-sh);
    end
  endfunction

  function automatic weight_word_t update_weight(grad_word_t w);
    weight_word_t r;
    longint s;
    longint unsigned mag_sum, avg, diff, lim, mag;
    logic [127:0] p;
    r.idx = w.idx;
    r.value = '0;
    r.sat = 1'b0;
    s = sums[w.idx] + longint'(w.grad);
    if (s > 64'sd140737488355327) s = 64'sd140737488355327;
    if (s < -64'sd140737488355328) s = -64'sd140737488355328;
    sums[w.idx] = s;
    mag_sum = s < 0 ? -s : s;
    avg = mag_sum / t_count;
    if (avg > lambda) begin
      diff = avg - lambda;
      lim = s > 0 ? (64'd1 << 31) : ((64'd1 << 31) - 1);
      p = 128'(scale) * 128'(diff);
      if (p[127:64] != 0) mag = lim + 1;
      else mag = p[63:0] >> 16;
      if (mag > lim) begin
        mag = lim;
        r.sat = 1'b1;
      end
      r.value = s > 0 ? -mag[31:0] : mag[31:0];
    end
    if (w.eob && t_count != 32'hFFFF_FFFF) begin
      t_count++;
      refresh_scale();
    end
    return r;
  endfunction

  task automatic report(string what, weight_word_t got, weight_word_t exp_w);
    $display("mismatch %s: got idx %0d val %0d sat %0d, want idx %0d val %0d sat %0d",
             what, got.idx, got.value, got.sat, exp_w.idx, exp_w.value, exp_w.sat);
    n_err++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.idx = feature_index;
        nxt.grad = grad_value;
        nxt.eob = end_of_batch;
        expected_weights.insert(expected_weights.size(), update_weight(nxt));
        n_sent++;
        if (nxt.eob) n_batches++;
      end
      if (!in_valid || !in_stall) begin
        if (grad_words.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
          nxt = grad_words.pop_front();
          in_valid <= 1'b1;
          feature_index <= nxt.idx;
          grad_value <= nxt.grad;
          end_of_batch <= nxt.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    weight_word_t got, exp_w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.idx = weight_index;
        got.value = weight_value;
        got.sat = weight_saturated;
        n_recv++;
        if (got.sat) n_sat++;
        if (expected_weights.size() == 0) begin
          exp_w = '{default: '0};
          report("unexpected word", got, exp_w);
        end else begin
          exp_w = expected_weights.pop_front();
          if (got.idx !== exp_w.idx) report("weight_index", got, exp_w);
          if (got.value !== exp_w.value) report("weight_value", got, exp_w);
          if (got.sat !== exp_w.sat) report("weight_saturated", got, exp_w);
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 31);
    end
  end

  always @(posedge clk) quiet <= (n_sent >= 500 && n_sent < 700);

  task automatic cfg_write(logic [rda_pkg::CFG_IDX_W-1:0] idx, logic [rda_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rda_pkg::REG_STEP_SIZE: begin
        alpha = data;
        refresh_scale();
      end
      rda_pkg::REG_L1_THRESHOLD: lambda = data;
      rda_pkg::REG_DECAY_RATE: begin
        decay = data[rda_pkg::DECAY_W-1:0];
        refresh_scale();
      end
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic add_word(int idx, logic [31:0] g, bit eob);
    grad_word_t w;
    w.idx = rda_pkg::IDX_W'(idx);
    w.grad = g;
    w.eob = eob;
    grad_words.insert(grad_words.size(), w);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (grad_words.size() != 0 || in_valid || expected_weights.size() != 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic random_words(int count);
    int idx;
    logic [31:0] g;
    for (int i = 0; i < count; i++) begin
      idx = ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(1023);
      case ($urandom_range(5))
        0: g = $urandom();
        1: g = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        2: g = 32'($signed($urandom_range(2000)) - 1000);
        default: g = 32'($signed($urandom_range(1 << 20)) - (1 << 19)) << $urandom_range(10);
      endcase
      add_word(idx, g, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    foreach (sums[i]) sums[i] = 0;
    t_count = 1;
    alpha = rda_pkg::STEP_RESET;
    lambda = rda_pkg::THR_RESET;
    decay = rda_pkg::DECAY_RESET;
    refresh_scale();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, zero sum, batch ends
    add_word(0, 32'h7FFF_FFFF, 0);
    add_word(0, 32'h7FFF_FFFF, 0);
    add_word(1023, 32'h8000_0000, 0);
    add_word(1023, 32'h8000_0000, 1);
    add_word(5, 32'h0001_0000, 0);
    add_word(5, 32'hFFFF_0000, 0);
    add_word(1023, 32'h7FFF_FFFF, 1);
    add_word(7, 32'h0000_0001, 0);
    add_word(7, 32'hFFFF_FFFF, 1);
    add_word(512, 32'h5555_5555, 0);
    add_word(341, 32'hAAAA_AAAA, 1);
    drain();

    cfg_write(rda_pkg::REG_STEP_SIZE, 32'hFFFF_FFFF);
    cfg_write(rda_pkg::REG_L1_THRESHOLD, 32'h0000_0000);
    cfg_write(rda_pkg::REG_DECAY_RATE, 32'h0001_FFFF);
    for (int i = 0; i < 8; i++) add_word(i, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, i[1]);
    add_word(9, 32'h0000_0010, 1);
    random_words(230);
    drain();

    cfg_write(rda_pkg::REG_STEP_SIZE, 32'h0000_0000);
    random_words(100);
    drain();

    cfg_write(rda_pkg::REG_STEP_SIZE, 32'h0001_8000);
    cfg_write(rda_pkg::REG_L1_THRESHOLD, 32'hFFFF_FFFF);
    cfg_write(rda_pkg::REG_DECAY_RATE, 32'h2_0000);
    random_words(150);
    drain();

    cfg_write(rda_pkg::REG_L1_THRESHOLD, 32'h0000_4000);
    cfg_write(rda_pkg::REG_DECAY_RATE, 32'h0_0000);
    random_words(400);
    drain();

    cfg_write(rda_pkg::REG_STEP_SIZE, $urandom());
    cfg_write(rda_pkg::REG_L1_THRESHOLD, $urandom_range(32'h0004_0000));
    cfg_write(rda_pkg::REG_DECAY_RATE, $urandom());
    random_words(400);
    drain();

    $display("covered %0d gradient words over %0d batch ends, %0d register writes",
             n_sent, n_batches, n_cfg);
    $display("%0d weights checked, %0d of them saturated", n_recv, n_sat);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
